[rtl/ica_pkg.sv]
package ica_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 16;
   localparam int CORDIC_STEPS_DEF    = 18;
   localparam int PERIOD_DIVISOR      = 1000;
   localparam int TABLE_LEN           = 24;
   localparam int PRE_SHIFT           = 14;

   localparam logic [15:0] ALPHA_MIN   = 16'd32768;
   localparam logic [15:0] ALPHA_MAX   = 16'd65470;
   localparam logic [15:0] ALPHA_RESET = 16'd64225;
   localparam logic [9:0]  PERIOD_RESET = 10'd5;

   localparam logic CSR_ALPHA  = 1'b0;
   localparam logic CSR_PERIOD = 1'b1;

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_CLEAR  = 1'b1;

   // item handed from front to back
   typedef struct packed {
      logic        mode;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] rate_x;
      logic signed [15:0] rate_y;
      logic signed [15:0] rate_z;
      logic        accel_ok;
   } item_type;

   // atan(2^-i) in degrees, unsigned q.24
   function automatic logic [29:0] atan_q24(input logic [4:0] i);
      logic [29:0] t;
      unique case (i)
         5'd0:  t = 30'd754974720;
         5'd1:  t = 30'd445687602;
         5'd2:  t = 30'd235489088;
         5'd3:  t = 30'd119537938;
         5'd4:  t = 30'd60000934;
         5'd5:  t = 30'd30029717;
         5'd6:  t = 30'd15018523;
         5'd7:  t = 30'd7509720;
         5'd8:  t = 30'd3754917;
         5'd9:  t = 30'd1877466;
         5'd10: t = 30'd938734;
         5'd11: t = 30'd469367;
         5'd12: t = 30'd234684;
         5'd13: t = 30'd117342;
         5'd14: t = 30'd58671;
         5'd15: t = 30'd29335;
         5'd16: t = 30'd14668;
         5'd17: t = 30'd7334;
         5'd18: t = 30'd3667;
         5'd19: t = 30'd1833;
         5'd20: t = 30'd917;
         5'd21: t = 30'd458;
         5'd22: t = 30'd229;
         5'd23: t = 30'd115;
         default: t = 30'd0;
      endcase
      return t;
   endfunction

endpackage

[rtl/ica_if.sv]
interface ica_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] rate_x;
   logic signed [15:0] rate_y;
   logic signed [15:0] rate_z;
   modport source (output valid, mode, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                   input ready);
   modport sink (input valid, mode, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                 output ready);
endinterface

interface ica_rsp_if #(parameter int FRAC = 16);
   logic        valid;
   logic        ready;
   logic signed [FRAC+9:0]  roll_angle;
   logic signed [FRAC+9:0]  pitch_angle;
   logic signed [FRAC+8:0]  heading;
   logic signed [47:0]      heading_total;
   logic        accel_used;
   modport source (output valid, roll_angle, pitch_angle, heading, heading_total,
                   accel_used, input ready);
   modport sink (input valid, roll_angle, pitch_angle, heading, heading_total,
                 accel_used, output ready);
endinterface

[rtl/ica_front.sv]
// accepts samples, classifies free fall, two-entry queue toward the back end
module ica_front (
   input  logic clock,
   input  logic reset,
   ica_req_if.sink req,
   output logic q_valid,
   input  logic q_pop,
   output ica_pkg::item_type q_item
);
   import ica_pkg::*;

   item_type q_ff [2];
   item_type q_in;
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic push;
   logic [33:0] sq_x, sq_y, sq_z;
   logic [35:0] n2;
   logic [49:0] n2s;

   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = q_ff[rd_ff];

   // free fall test: |a|^2 * 10000 >= 4096^2
   always_comb begin
      sq_x = 34'(unsigned'(32'(req.accel_x * req.accel_x)));
      sq_y = 34'(unsigned'(32'(req.accel_y * req.accel_y)));
      sq_z = 34'(unsigned'(32'(req.accel_z * req.accel_z)));
      n2 = 36'(sq_x) + 36'(sq_y) + 36'(sq_z);
      n2s = 50'(n2) * 50'd10000;
      q_in.mode = req.mode;
      q_in.accel_x = req.accel_x;
      q_in.accel_y = req.accel_y;
      q_in.accel_z = req.accel_z;
      q_in.rate_x = req.rate_x;
      q_in.rate_y = req.rate_y;
      q_in.rate_z = req.rate_z;
      q_in.accel_ok = (n2s >= 50'd16777216);
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
      rd_in = rd_ff ^ q_pop;
      wr_in = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= q_in;
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
   end
endmodule

[rtl/ica_cordic.sv]
// shared vectoring cordic, one micro-rotation per cycle
module ica_cordic #(
   parameter int FRAC  = ica_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int STEPS = ica_pkg::CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [33:0] x0,
   input  logic signed [33:0] y0,
   output logic done,
   output logic signed [FRAC+9:0] angle
);
   import ica_pkg::*;
   localparam int NS = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;
   localparam int SH = 24 - FRAC;
   localparam int AW = FRAC + 10;

   logic signed [36:0] x_ff, x_in, y_ff, y_in;
   logic signed [AW-1:0] z_ff, z_in;
   logic [4:0] i_ff, i_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic signed [36:0] dx, dy;
   logic [29:0] tab;
   logic signed [AW-1:0] ta;
   logic signed [AW-1:0] half;

   always_comb begin
      half = AW'(180) <<< FRAC;
      tab = atan_q24(i_ff);
      ta = AW'((31'(tab) + (31'(1) << (SH - 1))) >> SH);
      dx = x_ff >>> i_ff;
      dy = y_ff >>> i_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      i_in = i_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         busy_in = !(x0 == 0 && y0 == 0);
         done_in = (x0 == 0 && y0 == 0);
         i_in = '0;
         if (x0 < 0) begin
            z_in = (y0 >= 0) ? half : -half;
            x_in = -37'(x0); y_in = -37'(y0);
         end else begin
            z_in = '0;
            x_in = 37'(x0); y_in = 37'(y0);
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + dy; y_in = y_ff - dx; z_in = z_ff + ta;
         end else if (y_ff < 0) begin
            x_in = x_ff - dy; y_in = y_ff + dx; z_in = z_ff - ta;
         end
         i_in = i_ff + 5'd1;
         if (i_ff == 5'(NS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; i_ff <= i_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
   assign done = done_ff;
   assign angle = z_ff;
endmodule

[rtl/ica_back.sv]
// back end: sequencer for gyro steps, sqrt, two atan2 runs, blend, yaw and clear
module ica_back #(
   parameter int FRAC  = ica_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int STEPS = ica_pkg::CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_pop,
   input  ica_pkg::item_type q_item,
   input  logic [15:0] alpha,
   input  logic [9:0]  period,
   ica_rsp_if.source rsp
);
   import ica_pkg::*;
   localparam int AW = FRAC + 10;
   localparam int YW = FRAC + 9;
   localparam int SW = FRAC + 13;
   localparam int PW = FRAC + 32;
   localparam int WW = FRAC + 14;
   // 16 * PERIOD_DIVISOR is an odd factor shifted left by seven
   localparam int DSH = FRAC - 7;
   localparam int DIV_ODD = (16 * PERIOD_DIVISOR) >> 7;
   localparam int HALF_OFF = (8 * PERIOD_DIVISOR) >> 7;
   localparam longint RECIP_L = ((64'(1) << 32) + 64'(DIV_ODD) - 1) / 64'(DIV_ODD);
   localparam logic [25:0] RECIP = 26'(RECIP_L);
   localparam longint FULL = 64'(360) << FRAC;
   localparam longint HALF = 64'(180) << FRAC;
   localparam longint TMAX = (64'(1) << 47) - 1;

   typedef enum logic [3:0] {
      S_IDLE, S_GYRO, S_DIV, S_REM, S_FIN, S_SQRT, S_ROLL, S_WROLL, S_PITCH,
      S_WPITCH, S_BLEND, S_YAW, S_WRAP, S_OUT
   } state_type;

   state_type st_ff;
   item_type it_ff;
   logic [1:0] ax_ff;
   logic [25:0] gp_ff;
   logic [19:0] gq_ff;
   logic [FRAC:0] gf_ff;
   logic signed [47:0] d_ff [3];
   logic [63:0] sv_ff, sr_ff, sb_ff;
   logic signed [AW-1:0] roll_ff, pitch_ff, aroll_ff, apitch_ff;
   logic signed [YW-1:0] yaw_ff;
   logic signed [WW-1:0] wr_ff;
   logic signed [47:0] tot_ff;
   logic first_ff, used_ff, ovalid_ff;
   logic signed [AW-1:0] o_roll_ff, o_pitch_ff;
   logic signed [YW-1:0] o_yaw_ff;
   logic signed [47:0] o_tot_ff;
   logic o_used_ff;

   logic c_start, c_done;
   logic signed [33:0] c_x, c_y;
   logic signed [AW-1:0] c_ang;

   logic signed [15:0] rsel;
   logic [15:0] rmag;
   logic [51:0] gq_full;
   logic [FRAC+26:0] gr_full;
   logic [6:0] g_rem;
   logic [47:0] g_quo;
   logic [63:0] bit_try;
   logic signed [SW-1:0] er, ep;
   logic signed [PW-1:0] pr, pp;
   logic signed [63:0] ta, ty;
   logic signed [AW-1:0] sr, sp;
   logic o_load;

   ica_cordic #(.FRAC(FRAC), .STEPS(STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(c_start), .x0(c_x), .y0(c_y),
      .done(c_done), .angle(c_ang));

   function automatic logic signed [AW-1:0] sat(input logic signed [PW-1:0] v);
      if (v > PW'(FULL)) return AW'(FULL);
      if (v < -PW'(FULL)) return AW'(-FULL);
      return AW'(v);
   endfunction

   always_comb begin
      rsel = (ax_ff == 2'd0) ? it_ff.rate_x : (ax_ff == 2'd1) ? it_ff.rate_y : it_ff.rate_z;
      rmag = rsel[15] ? 16'(-17'(rsel)) : 16'(rsel);
      // floor division by the odd factor through a reciprocal
      gq_full = 52'(gp_ff) * 52'(RECIP);
      g_rem = 7'(gp_ff - 26'(gq_ff) * 26'(DIV_ODD));
      gr_full = (FRAC+27)'(gf_ff) * (FRAC+27)'(RECIP);
      g_quo = (48'(gq_ff) << DSH) + 48'(gr_full[FRAC+26:32]);
      bit_try = sr_ff + sb_ff;
      c_start = (st_ff == S_ROLL) || (st_ff == S_PITCH);
      c_x = (st_ff == S_ROLL) ? (34'(it_ff.accel_z) <<< PRE_SHIFT) : 34'(sr_ff);
      c_y = (st_ff == S_ROLL) ? (34'(it_ff.accel_y) <<< PRE_SHIFT)
                              : -(34'(it_ff.accel_x) <<< PRE_SHIFT);
      er = SW'(roll_ff) + SW'(d_ff[0]);
      ep = SW'(pitch_ff) + SW'(d_ff[1]);
      pr = PW'($signed({1'b0, alpha})) * PW'(er)
         + PW'($signed(18'd65536 - 18'(alpha))) * PW'(aroll_ff)
         + PW'(32768);
      pp = PW'($signed({1'b0, alpha})) * PW'(ep)
         + PW'($signed(18'd65536 - 18'(alpha))) * PW'(apitch_ff)
         + PW'(32768);
      sr = sat(pr >>> 16);
      sp = sat(pp >>> 16);
      ta = 64'(tot_ff) + 64'(d_ff[2]);
      ty = 64'(yaw_ff) + 64'(d_ff[2]);
   end

   assign q_pop = (st_ff == S_IDLE) && q_valid;
   assign o_load = (st_ff == S_OUT) && (!ovalid_ff || rsp.ready);
   assign rsp.valid = ovalid_ff;
   assign rsp.roll_angle = o_roll_ff;
   assign rsp.pitch_angle = o_pitch_ff;
   assign rsp.heading = o_yaw_ff;
   assign rsp.heading_total = o_tot_ff;
   assign rsp.accel_used = o_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         ovalid_ff <= 1'b0;
         roll_ff <= '0; pitch_ff <= '0; yaw_ff <= '0; tot_ff <= '0;
         first_ff <= 1'b1;
      end else begin
         ovalid_ff <= o_load || (ovalid_ff && !rsp.ready);
         unique case (st_ff)
            S_IDLE: begin
               if (q_pop) begin
                  it_ff <= q_item;
                  if (q_item.mode == MODE_CLEAR) begin
                     yaw_ff <= '0; tot_ff <= '0; used_ff <= 1'b0;
                     st_ff <= S_OUT;
                  end else begin
                     ax_ff <= 2'd0;
                     st_ff <= S_GYRO;
                  end
               end
            end
            // rate magnitude * period, then divide with round to nearest
            S_GYRO: begin
               gp_ff <= 26'(rmag) * 26'(period);
               st_ff <= S_DIV;
            end
            S_DIV: begin
               gq_ff <= gq_full[51:32];
               st_ff <= S_REM;
            end
            S_REM: begin
               gf_ff <= ((FRAC+1)'(g_rem) << DSH) + (FRAC+1)'(HALF_OFF);
               st_ff <= S_FIN;
            end
            S_FIN: begin
               d_ff[ax_ff] <= rsel[15] ? -g_quo : g_quo;
               if (ax_ff == 2'd2) begin
                  aroll_ff <= roll_ff; apitch_ff <= pitch_ff;
                  used_ff <= it_ff.accel_ok;
                  sv_ff <= 64'(unsigned'(32'(it_ff.accel_y * it_ff.accel_y))
                               + unsigned'(32'(it_ff.accel_z * it_ff.accel_z)))
                           << (2 * PRE_SHIFT);
                  sr_ff <= '0; sb_ff <= 64'(1) << 62;
                  st_ff <= it_ff.accel_ok ? S_SQRT : S_BLEND;
               end else begin
                  ax_ff <= ax_ff + 2'd1;
                  st_ff <= S_GYRO;
               end
            end
            // bit-pair integer square root
            S_SQRT: begin
               if (sb_ff == 64'd0) st_ff <= S_ROLL;
               else if (sb_ff > sv_ff && sr_ff == 64'd0) sb_ff <= sb_ff >> 2;
               else begin
                  if (sv_ff >= bit_try) begin
                     sv_ff <= sv_ff - bit_try;
                     sr_ff <= (sr_ff >> 1) + sb_ff;
                  end else sr_ff <= sr_ff >> 1;
                  sb_ff <= sb_ff >> 2;
               end
            end
            S_ROLL: st_ff <= S_WROLL;
            S_WROLL: if (c_done) begin aroll_ff <= c_ang; st_ff <= S_PITCH; end
            S_PITCH: st_ff <= S_WPITCH;
            S_WPITCH: if (c_done) begin apitch_ff <= c_ang; st_ff <= S_BLEND; end
            S_BLEND: begin
               if (first_ff) begin
                  roll_ff <= sat(PW'(aroll_ff));
                  pitch_ff <= sat(PW'(apitch_ff));
                  first_ff <= 1'b0;
               end else begin
                  roll_ff <= sr; pitch_ff <= sp;
               end
               st_ff <= S_YAW;
            end
            S_YAW: begin
               if (ta > TMAX) tot_ff <= 48'(TMAX);
               else if (ta < -TMAX) tot_ff <= 48'(-TMAX);
               else tot_ff <= 48'(ta);
               wr_ff <= WW'(ty);
               st_ff <= S_WRAP;
            end
            // one turn per cycle until the heading lands in (-180, 180]
            S_WRAP: begin
               if (wr_ff > HALF) wr_ff <= wr_ff - WW'(FULL);
               else if (wr_ff <= -HALF) wr_ff <= wr_ff + WW'(FULL);
               else begin
                  yaw_ff <= YW'(wr_ff);
                  st_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (o_load) begin
                  o_roll_ff <= roll_ff; o_pitch_ff <= pitch_ff;
                  o_yaw_ff <= yaw_ff; o_tot_ff <= tot_ff;
                  o_used_ff <= used_ff;
                  st_ff <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[rtl/imu_complementary_attitude.sv]
// channel   dir   payload
// req_      in    mode, accel_x/y/z, rate_x/y/z
// rsp_      out   roll_angle, pitch_angle, heading, heading_total, accel_used
// csr_      in    write enable, index, 16-bit data
//
// per sample: three reciprocal divides for gyro steps, a square root and two
// cordic runs on one shared unit, then a heading wrap; free-fall beats skip the
// square root and cordic runs, and clear beats go straight to the output
// synchronous reset loads register defaults and clears all estimates
// a two-beat queue and the output register let the front keep taking beats
// while the back stalls
module imu_complementary_attitude #(
   parameter int ANGLE_FRAC_BITS = ica_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS    = ica_pkg::CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   ica_req_if.sink req,
   ica_rsp_if.source rsp,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import ica_pkg::*;

   logic [15:0] alpha_ff;
   logic [9:0]  period_ff;
   logic q_valid, q_pop;
   item_type q_item;

   // config registers, alpha clamped on write
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         period_ff <= PERIOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ALPHA: begin
               if (csr_wdata < ALPHA_MIN) alpha_ff <= ALPHA_MIN;
               else if (csr_wdata > ALPHA_MAX) alpha_ff <= ALPHA_MAX;
               else alpha_ff <= csr_wdata;
            end
            CSR_PERIOD: period_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // front: accept and free-fall classify
   ica_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item));

   // back: arithmetic sequencer and output register
   ica_back #(.FRAC(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop),
      .q_item(q_item), .alpha(alpha_ff), .period(period_ff), .rsp(rsp));
endmodule
